>>> hdl/rc4_pkg.sv
// Package for the RC4 stream cipher core: state encoding, operation codes and fixed sizes.
// Used by rc4_stream_cipher_core and its testbench; no dependencies of its own.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COUNT_W    = 9;
  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRJ,
    ST_DSWI,
    ST_DSWJ,
    ST_EMIT,
    ST_KRN,
    ST_KRA,
    ST_KWN,
    ST_KWA
  } state_t;

endpackage

>>> hdl/rc4_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; instanced for the permutation and the key store.
`timescale 1ns / 1ps

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/rc4_stream_cipher_core.sv
// RC4 engine: a data item runs DRJ, DSWI, DSWJ (and EMIT while the output is held), by the
// read, read, swap-write, swap-write sequence on the permutation RAM; no new item is taken
// until it is done. The last key item starts the schedule: one KRN, KRA, KWN, KWA step per entry.
// Reset (rst_n low, synchronous) clears control state and the permutation valid bits, so the
// permutation reads as the identity at once; key store contents are undefined until written.
// Depends on rc4_pkg and rc4_ram.
`timescale 1ns / 1ps

module rc4_stream_cipher_core #(
  parameter int KEY_MAX_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_byte_in,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_out,
  output logic       out_last_out
);

  localparam int KA_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam logic [rc4_pkg::COUNT_W-1:0] KEY_MAX_C = rc4_pkg::COUNT_W'(KEY_MAX_BYTES);

  rc4_pkg::state_t state_r, state_nxt;

  logic [7:0] i_r, i_nxt;
  logic [7:0] j_r, j_nxt;
  logic [7:0] si_r, si_nxt;
  logic [7:0] sj_r, sj_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [7:0] n_r, n_nxt;
  logic [7:0] data_r, data_nxt;
  logic       last_r, last_nxt;
  logic [KA_W-1:0] kpos_r, kpos_nxt;
  logic [rc4_pkg::COUNT_W-1:0] len_r, len_nxt;
  logic [rc4_pkg::COUNT_W-1:0] key_count_r, key_count_nxt;
  logic [rc4_pkg::TABLE_SIZE-1:0] vld_r;
  logic       vld_clear;
  logic [7:0] rd_addr_r;
  logic       rd_vld_r;
  logic [7:0] res_byte_r, res_byte_nxt;
  logic       res_last_r, res_last_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic [7:0] p_raddr, p_waddr, p_wdata, p_rdata, p_eff;
  logic       p_we;
  logic       k_we;
  logic [KA_W-1:0] k_waddr;
  logic [7:0] k_rdata;

  logic       accept;
  logic       out_free;
  logic       key_room;
  logic [7:0] acc_sum;
  logic [7:0] ks_val;
  logic [7:0] cipher;
  logic [rc4_pkg::COUNT_W-1:0] kpos_inc;

  rc4_ram #(.WIDTH(8), .DEPTH(rc4_pkg::TABLE_SIZE)) u_perm_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(.WIDTH(8), .DEPTH(KEY_MAX_BYTES)) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (in_byte_in),
    .raddr (kpos_r),
    .rdata (k_rdata)
  );

  assign in_ready     = rst_n && (state_r == rc4_pkg::ST_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_byte_out = out_byte_r;
  assign out_last_out = out_last_r;
  assign out_free     = !out_valid_r || out_ready;
  assign key_room     = (key_count_r < KEY_MAX_C);
  assign k_we         = accept && (in_operation == rc4_pkg::OP_KEY) && key_room;
  assign k_waddr      = key_count_r[KA_W-1:0];

  // An entry not yet written since the last identity load reads as its own index.
  assign p_eff    = rd_vld_r ? p_rdata : rd_addr_r;
  assign acc_sum  = acc_r + k_rdata + p_eff;
  assign ks_val   = (rd_addr_r == i_r) ? sj_r : ((rd_addr_r == j_r) ? si_r : p_eff);
  assign cipher   = data_r ^ ks_val;
  assign kpos_inc = rc4_pkg::COUNT_W'(kpos_r) + 9'd1;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    acc_nxt       = acc_r;
    n_nxt         = n_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    kpos_nxt      = kpos_r;
    len_nxt       = len_r;
    key_count_nxt = key_count_r;
    res_byte_nxt  = res_byte_r;
    res_last_nxt  = res_last_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    vld_clear     = 1'b0;
    p_raddr       = i_r;
    p_we          = 1'b0;
    p_waddr       = i_r;
    p_wdata       = sj_r;
    case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation == rc4_pkg::OP_DATA) begin
            i_nxt     = i_r + 8'd1;
            p_raddr   = i_r + 8'd1;
            data_nxt  = in_byte_in;
            last_nxt  = in_last;
            state_nxt = rc4_pkg::ST_DRJ;
          end else begin
            if (key_room) begin
              key_count_nxt = key_count_r + 9'd1;
            end
            if (in_last) begin
              len_nxt   = key_count_nxt;
              vld_clear = 1'b1;
              n_nxt     = 8'd0;
              acc_nxt   = 8'd0;
              kpos_nxt  = '0;
              state_nxt = rc4_pkg::ST_KRN;
            end
          end
        end
      end
      rc4_pkg::ST_DRJ: begin
        si_nxt    = p_eff;
        j_nxt     = j_r + p_eff;
        p_raddr   = j_r + p_eff;
        state_nxt = rc4_pkg::ST_DSWI;
      end
      rc4_pkg::ST_DSWI: begin
        sj_nxt    = p_eff;
        p_we      = 1'b1;
        p_waddr   = i_r;
        p_wdata   = p_eff;
        p_raddr   = si_r + p_eff;
        state_nxt = rc4_pkg::ST_DSWJ;
      end
      rc4_pkg::ST_DSWJ: begin
        p_we    = 1'b1;
        p_waddr = j_r;
        p_wdata = si_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = cipher;
          out_last_nxt  = last_r;
          state_nxt     = rc4_pkg::ST_IDLE;
        end else begin
          res_byte_nxt = cipher;
          res_last_nxt = last_r;
          state_nxt    = rc4_pkg::ST_EMIT;
        end
      end
      rc4_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_byte_r;
          out_last_nxt  = res_last_r;
          state_nxt     = rc4_pkg::ST_IDLE;
        end
      end
      rc4_pkg::ST_KRN: begin
        p_raddr   = n_r;
        state_nxt = rc4_pkg::ST_KRA;
      end
      rc4_pkg::ST_KRA: begin
        si_nxt    = p_eff;
        acc_nxt   = acc_sum;
        p_raddr   = acc_sum;
        state_nxt = rc4_pkg::ST_KWN;
      end
      rc4_pkg::ST_KWN: begin
        p_we      = 1'b1;
        p_waddr   = n_r;
        p_wdata   = p_eff;
        state_nxt = rc4_pkg::ST_KWA;
      end
      rc4_pkg::ST_KWA: begin
        p_we     = 1'b1;
        p_waddr  = acc_r;
        p_wdata  = si_r;
        n_nxt    = n_r + 8'd1;
        kpos_nxt = (kpos_inc >= len_r) ? '0 : KA_W'(kpos_inc);
        if (n_r == rc4_pkg::BYTE_MASK) begin
          i_nxt         = 8'd0;
          j_nxt         = 8'd0;
          key_count_nxt = '0;
          state_nxt     = rc4_pkg::ST_IDLE;
        end else begin
          state_nxt = rc4_pkg::ST_KRN;
        end
      end
      default: begin
        state_nxt = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4_pkg::ST_IDLE;
      i_r         <= 8'd0;
      j_r         <= 8'd0;
      key_count_r <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      key_count_r <= key_count_nxt;
      out_valid_r <= out_valid_nxt;
      if (vld_clear) begin
        vld_r <= '0;
      end else if (p_we) begin
        vld_r[p_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    acc_r      <= acc_nxt;
    n_r        <= n_nxt;
    data_r     <= data_nxt;
    last_r     <= last_nxt;
    kpos_r     <= kpos_nxt;
    len_r      <= len_nxt;
    res_byte_r <= res_byte_nxt;
    res_last_r <= res_last_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    rd_addr_r  <= p_raddr;
    rd_vld_r   <= vld_r[p_raddr];
  end

`ifndef SYNTHESIS
  a_data_reaches_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == rc4_pkg::OP_DATA) |-> ##3 (state_r == rc4_pkg::ST_DSWJ))
    else $error("Data item did not reach the second swap write on time.");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rc4_pkg::ST_IDLE) |-> !p_we)
    else $error("Permutation written while idle.");

  a_schedule_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == rc4_pkg::OP_KEY && in_last) |=>
      (vld_r == '0 && state_r == rc4_pkg::ST_KRN))
    else $error("Key schedule did not start from the identity.");

  a_schedule_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rc4_pkg::ST_KWA && n_r == rc4_pkg::BYTE_MASK) |=>
      (i_r == 8'd0 && j_r == 8'd0 && key_count_r == '0 && state_r == rc4_pkg::ST_IDLE))
    else $error("Indices or key count not cleared after the schedule.");

  a_key_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= KEY_MAX_C)
    else $error("Key count beyond the key store depth.");
`endif

endmodule

>>> bench/rc4_stream_cipher_core_test.sv
// Self-checking testbench for rc4_stream_cipher_core: key loading, key schedule and data ciphering.
// An internal RC4 predictor computes every expected byte; needs only rc4_pkg and the core RTL.
`timescale 1ns / 1ps

module rc4_stream_cipher_core_test;

  localparam int KEY_LIMIT = 256;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 1100;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_out;
  } cipher_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_operation;
  logic [7:0] in_byte_in;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte_out;
  logic       out_last_out;

  logic [7:0] sbox [rc4_pkg::TABLE_SIZE];
  logic [7:0] key_bytes [rc4_pkg::TABLE_SIZE];
  int         key_len;
  logic [7:0] idx_i;
  logic [7:0] idx_j;

  cipher_result_t pending_results [$];
  int n_errors = 0;
  int items_sent = 0;
  bit idle_on = 1'b1;

  rc4_stream_cipher_core #(
    .KEY_MAX_BYTES(KEY_LIMIT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_byte_in(in_byte_in),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte_out(out_byte_out),
    .out_last_out(out_last_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_cipher_state();
    for (int n = 0; n < rc4_pkg::TABLE_SIZE; n++) begin
      sbox[n] = 8'(n);
      key_bytes[n] = 8'h00;
    end
    key_len = 0;
    idx_i = 8'h00;
    idx_j = 8'h00;
  endfunction

  function automatic void run_key_schedule();
    logic [7:0] acc;
    logic [7:0] t;
    int kpos;
    int len;
    len = (key_len == 0) ? 1 : key_len;
    for (int n = 0; n < rc4_pkg::TABLE_SIZE; n++) begin
      sbox[n] = 8'(n);
    end
    acc = 8'h00;
    kpos = 0;
    for (int n = 0; n < rc4_pkg::TABLE_SIZE; n++) begin
      acc = acc + key_bytes[kpos] + sbox[n];
      t = sbox[n];
      sbox[n] = sbox[acc];
      sbox[acc] = t;
      kpos++;
      if (kpos >= len) begin
        kpos = 0;
      end
    end
    idx_i = 8'h00;
    idx_j = 8'h00;
    key_len = 0;
  endfunction

  function automatic void predict_item(input logic op, input logic [7:0] b, input logic lst);
    logic [7:0] t;
    logic [7:0] ks_idx;
    cipher_result_t r;
    if (op == rc4_pkg::OP_KEY) begin
      if (key_len < KEY_LIMIT) begin
        key_bytes[key_len] = b;
        key_len++;
      end
      if (lst) begin
        run_key_schedule();
      end
    end else begin
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + sbox[idx_i];
      t = sbox[idx_i];
      sbox[idx_i] = sbox[idx_j];
      sbox[idx_j] = t;
      ks_idx = sbox[idx_i] + sbox[idx_j];
      r.byte_out = b ^ sbox[ks_idx];
      r.last_out = lst;
      pending_results.push_back(r);
    end
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b, input logic lst);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_byte_in <= b;
    in_last <= lst;
    do @(posedge clk); while (!in_ready);
    predict_item(op, b, lst);
    items_sent++;
  endtask

  task automatic send_key(input int len, input bit mark_last);
    for (int k = 0; k < len; k++) begin
      send_item(rc4_pkg::OP_KEY, 8'($urandom), mark_last && (k == len - 1));
    end
  endtask

  task automatic send_buffer(input int len);
    for (int k = 0; k < len; k++) begin
      send_item(rc4_pkg::OP_DATA, 8'($urandom), (k == len - 1) || ($urandom_range(0, 15) == 0));
    end
  endtask

  task automatic test_data_before_key();
    send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'hff, 1'b1);
    send_item(rc4_pkg::OP_DATA, 8'h5a, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'ha5, 1'b1);
  endtask

  task automatic test_single_byte_key();
    send_item(rc4_pkg::OP_KEY, 8'hff, 1'b1);
    send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'hff, 1'b1);
    send_item(rc4_pkg::OP_KEY, 8'h00, 1'b1);
    send_item(rc4_pkg::OP_DATA, 8'h80, 1'b1);
  endtask

  task automatic test_data_during_key_load();
    string pt;
    pt = "Plaintext";
    send_item(rc4_pkg::OP_KEY, "K", 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'h12, 1'b0);
    send_item(rc4_pkg::OP_KEY, "e", 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'h34, 1'b1);
    send_item(rc4_pkg::OP_KEY, "y", 1'b1);
    for (int k = 0; k < pt.len(); k++) begin
      send_item(rc4_pkg::OP_DATA, pt[k], k == pt.len() - 1);
    end
  endtask

  task automatic test_key_overflow();
    send_key(KEY_LIMIT + 2, 1'b0);
    send_item(rc4_pkg::OP_KEY, 8'($urandom), 1'b1);
    send_buffer(8);
    send_key(KEY_LIMIT, 1'b1);
    send_buffer(8);
  endtask

  task automatic test_random_sessions(input int budget);
    int stop_at;
    int klen;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        klen = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 260) : $urandom_range(1, 16);
        send_key(klen, 1'b1);
        send_buffer($urandom_range(1, 40));
      end else begin
        repeat ($urandom_range(1, 12)) begin
          send_item(1'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
        end
      end
    end
  endtask

  task automatic test_back_to_back(input int budget);
    idle_on = 1'b0;
    test_random_sessions(budget);
  endtask

  initial begin : sink_ready
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cipher_result_t r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: byte_out %02h, last_out %0b", out_byte_out, out_last_out);
        n_errors++;
      end else begin
        r = pending_results.pop_front();
        if (out_byte_out !== r.byte_out) begin
          $error("byte_out mismatch: expected %02h, actual %02h", r.byte_out, out_byte_out);
          n_errors++;
        end
        if (out_last_out !== r.last_out) begin
          $error("last_out mismatch: expected %0b, actual %0b", r.last_out, out_last_out);
          n_errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= rc4_pkg::OP_KEY;
    in_byte_in <= 8'h00;
    in_last <= 1'b0;
    clear_cipher_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_data_before_key();
    test_single_byte_key();
    test_data_during_key_load();
    test_key_overflow();
    test_random_sessions(450);
    test_back_to_back(200);
    send_buffer(4);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
